// ----- hdl/maxp_pkg.sv -----
// ----------------------------------------------------------------------------
// maxp_pkg
// Shared types and constants of the 2x2 max pooling stream block.
// ----------------------------------------------------------------------------
package maxp_pkg;

    // Width of the sample and pooled value fields on the stream ports.
    localparam int SAMPLE_W = 32;

    // Configuration port geometry.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM       = 1'd1;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RESET_CHANNEL_COUNT = 7'd6;
    localparam logic [CFG_W-1:0] RESET_OUT_DIM       = 7'd14;

    // Channel counter.
    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = 6;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Classification of one sample, made by the front and used by the back.
    typedef struct packed {
        logic col_odd;   // right sample of a horizontal pair
        logic row_odd;   // bottom row of a window
        logic map_last;  // completes the last window of the last channel
    } item_ctrl_t;

endpackage

// ----- hdl/maxp_ram.sv -----
// ----------------------------------------------------------------------------
// maxp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module maxp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/maxp_queue.sv -----
// ----------------------------------------------------------------------------
// maxp_queue
// Short register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module maxp_queue #(
    parameter int WIDTH = 40
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  logic [WIDTH-1:0]                 push_data,
    output logic                             push_ready,
    input  logic                             pop,
    output logic                             pop_valid,
    output logic [WIDTH-1:0]                 pop_data,
    output logic [maxp_pkg::QUEUE_CNT_W-1:0] fill
);

    logic [WIDTH-1:0]                 slot_reg [maxp_pkg::QUEUE_DEPTH];
    logic [maxp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [maxp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [maxp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != maxp_pkg::QUEUE_CNT_W'(maxp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign fill       = count_reg;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/maxp_front.sv -----
// ----------------------------------------------------------------------------
// maxp_front
// Accepts samples, tracks column, row and channel position and tags each
// sample with its place in the 2x2 window grid. Holds the configuration.
// ----------------------------------------------------------------------------
module maxp_front #(
    parameter int MAX_OUT_DIM = 64,
    parameter int VAL_W       = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [maxp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [maxp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    input  logic [maxp_pkg::SAMPLE_W-1:0]     in_data,
    input  logic                              queue_ready,
    output logic                              push,
    output logic signed [VAL_W-1:0]           push_sample,
    output logic [((MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1)-1:0] push_slot,
    output maxp_pkg::item_ctrl_t              push_ctrl
);

    localparam int COL_W  = $clog2(2 * MAX_OUT_DIM);
    localparam int SLOT_W = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;

    // Last column index of a row (2*dim - 1) with the dimension clamped.
    function automatic logic [COL_W-1:0] span_last(input logic [maxp_pkg::CFG_W-1:0] v);
        logic [maxp_pkg::CFG_W-1:0] d;
        logic [maxp_pkg::CFG_W+1:0] s;
        d = v;
        if (v == '0) begin
            d = maxp_pkg::CFG_W'(1);
        end else if (int'(v) > MAX_OUT_DIM) begin
            d = maxp_pkg::CFG_W'(MAX_OUT_DIM);
        end
        s = {1'b0, d, 1'b0} - 1'b1;
        return COL_W'(s);
    endfunction

    // Last channel index with the channel count clamped.
    function automatic logic [maxp_pkg::CH_W-1:0] chan_last(
        input logic [maxp_pkg::CFG_W-1:0] v
    );
        logic [maxp_pkg::CFG_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = maxp_pkg::CFG_W'(1);
        end else if (int'(v) > maxp_pkg::MAX_CHANNELS) begin
            c = maxp_pkg::CFG_W'(maxp_pkg::MAX_CHANNELS);
        end
        return maxp_pkg::CH_W'(c - 1'b1);
    endfunction

    logic [COL_W-1:0]          col_last_reg, col_last_next;
    logic [maxp_pkg::CH_W-1:0] ch_last_reg, ch_last_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [COL_W-1:0]          row_reg, row_next;
    logic [maxp_pkg::CH_W-1:0] ch_reg, ch_next;
    logic                      restart;
    logic                      last_col, last_row, last_ch;

    assign push     = in_valid && queue_ready;
    assign last_col = (col_reg == col_last_reg);
    assign last_row = (row_reg == col_last_reg);
    assign last_ch  = (ch_reg == ch_last_reg);

    // Classification of the current sample.
    assign push_sample        = in_data[VAL_W-1:0];
    assign push_slot          = SLOT_W'(col_reg >> 1);
    assign push_ctrl.col_odd  = col_reg[0];
    assign push_ctrl.row_odd  = row_reg[0];
    assign push_ctrl.map_last = last_col && last_row && last_ch;

    // Configuration writes; either register restarts the map.
    always_comb begin
        col_last_next = col_last_reg;
        ch_last_next  = ch_last_reg;
        restart       = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                maxp_pkg::REG_CHANNEL_COUNT: begin
                    ch_last_next = chan_last(cfg_wdata);
                    restart      = 1'b1;
                end
                maxp_pkg::REG_OUT_DIM: begin
                    col_last_next = span_last(cfg_wdata);
                    restart       = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Position counters: column, then row, then channel, wrapping after the map.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        ch_next  = ch_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
            ch_next  = '0;
        end else if (push) begin
            if (!last_col) begin
                col_next = col_reg + 1'b1;
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + 1'b1;
                end else begin
                    row_next = '0;
                    ch_next  = last_ch ? '0 : ch_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg <= span_last(maxp_pkg::RESET_OUT_DIM);
            ch_last_reg  <= chan_last(maxp_pkg::RESET_CHANNEL_COUNT);
            col_reg      <= '0;
            row_reg      <= '0;
            ch_reg       <= '0;
        end else begin
            col_last_reg <= col_last_next;
            ch_last_reg  <= ch_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ch_reg       <= ch_next;
        end
    end

endmodule

// ----- hdl/maxp_back.sv -----
// ----------------------------------------------------------------------------
// maxp_back
// Pops classified samples, forms horizontal pair maxima, keeps the even-row
// pair maxima in a line buffer and emits each window maximum through an
// output register.
// ----------------------------------------------------------------------------
module maxp_back #(
    parameter int MAX_OUT_DIM = 64,
    parameter int VAL_W       = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  logic signed [VAL_W-1:0]           head_sample,
    input  logic [((MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1)-1:0] head_slot,
    input  maxp_pkg::item_ctrl_t              head_ctrl,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [maxp_pkg::SAMPLE_W-1:0]     out_data,
    output logic                              out_last
);

    localparam int SLOT_W = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;

    logic signed [VAL_W-1:0]       pair_reg;
    logic                          e_valid_reg;
    logic signed [VAL_W-1:0]       e_pm_reg;
    logic [SLOT_W-1:0]             e_slot_reg;
    logic                          e_row_odd_reg;
    logic                          e_last_reg;
    logic                          o_valid_reg;
    logic [maxp_pkg::SAMPLE_W-1:0] o_data_reg;
    logic                          o_last_reg;

    logic                          o_free, e_adv, e_free;
    logic signed [VAL_W-1:0]       pm;
    logic signed [VAL_W-1:0]       stored_pm;
    logic signed [VAL_W-1:0]       window_max;
    logic                          rd_en, wr_en;

    // Handshake between the stages.
    assign o_free = !o_valid_reg || out_ready;
    assign e_adv  = e_valid_reg && (!e_row_odd_reg || o_free);
    assign e_free = !e_valid_reg || e_adv;
    assign pop    = head_valid && (!head_ctrl.col_odd || e_free);

    // Pair maximum of the left sample and the right one.
    assign pm = (head_sample > pair_reg) ? head_sample : pair_reg;

    // Line buffer: read when a bottom-row pair enters, write when a top-row pair leaves.
    assign rd_en = pop && head_ctrl.col_odd && head_ctrl.row_odd;
    assign wr_en = e_adv && !e_row_odd_reg;

    maxp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_OUT_DIM)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (e_slot_reg),
        .wr_data (e_pm_reg),
        .rd_en   (rd_en),
        .rd_addr (head_slot),
        .rd_data (stored_pm)
    );

    assign window_max = (stored_pm > e_pm_reg) ? stored_pm : e_pm_reg;

    // Left sample of the current pair.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else if (pop && !head_ctrl.col_odd) begin
            pair_reg <= head_sample;
        end
    end

    // Execute stage holding one pair maximum.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (pop && head_ctrl.col_odd) begin
            e_valid_reg <= 1'b1;
        end else if (e_adv) begin
            e_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_ctrl.col_odd) begin
            e_pm_reg      <= pm;
            e_slot_reg    <= head_slot;
            e_row_odd_reg <= head_ctrl.row_odd;
            e_last_reg    <= head_ctrl.map_last;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (e_adv && e_row_odd_reg) begin
            o_valid_reg <= 1'b1;
        end else if (out_ready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_adv && e_row_odd_reg) begin
            o_data_reg <= maxp_pkg::SAMPLE_W'(window_max);
            o_last_reg <= e_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;
    assign out_last  = o_last_reg;

endmodule

// ----- hdl/maxpool_2x2_stream_top.sv -----
// ----------------------------------------------------------------------------
// maxpool_2x2_stream_top
// Streaming 2x2 max pooling with stride 2 over channel-major feature maps.
//
//   Channel   Direction  Content
//   s_axis    in         tdata = sample (signed)
//   m_axis    out        tdata = pooled_value (signed), tlast = map_last
//   cfg       in         index 0 channel_count, index 1 out_dim
//
// One sample is accepted per cycle, sustained while the output is not stalled; the line
// buffer RAM has one write and one read port, which sets that rate.
// A window maximum passes the queue, execute stage and output register.
// Reset clears counters and valid flags; the line buffer is not cleared.
// A four-word queue lets the input side keep going while the output stalls.
// ----------------------------------------------------------------------------
module maxpool_2x2_stream_top #(
    parameter int MAX_OUT_DIM = 64,
    parameter int DATA_W      = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [maxp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [maxp_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [maxp_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [31:0] sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [maxp_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [31:0] pooled_value
    output logic                               m_axis_tlast
);

    localparam int VAL_W  = (DATA_W < maxp_pkg::SAMPLE_W) ? DATA_W : maxp_pkg::SAMPLE_W;
    localparam int SLOT_W = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;
    localparam int CTRL_W = $bits(maxp_pkg::item_ctrl_t);
    localparam int Q_W    = SLOT_W + VAL_W + CTRL_W;

    logic                             q_push, q_ready, q_pop, q_valid;
    logic [Q_W-1:0]                   q_in, q_out;
    logic [maxp_pkg::QUEUE_CNT_W-1:0] q_fill;
    logic signed [VAL_W-1:0]          f_sample, h_sample;
    logic [SLOT_W-1:0]                f_slot, h_slot;
    maxp_pkg::item_ctrl_t             f_ctrl, h_ctrl;

    // Front: position tracking and classification.
    maxp_front #(
        .MAX_OUT_DIM (MAX_OUT_DIM),
        .VAL_W       (VAL_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .queue_ready (q_ready),
        .push        (q_push),
        .push_sample (f_sample),
        .push_slot   (f_slot),
        .push_ctrl   (f_ctrl)
    );

    assign s_axis_tready = q_ready;
    assign q_in          = {f_slot, f_sample, f_ctrl};

    // Queue between front and back.
    maxp_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out),
        .fill       (q_fill)
    );

    assign h_slot   = q_out[Q_W-1 -: SLOT_W];
    assign h_sample = q_out[CTRL_W +: VAL_W];
    assign h_ctrl   = maxp_pkg::item_ctrl_t'(q_out[CTRL_W-1:0]);

    // Back: pair maxima, line buffer and output register.
    maxp_back #(
        .MAX_OUT_DIM (MAX_OUT_DIM),
        .VAL_W       (VAL_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_valid),
        .head_sample (h_sample),
        .head_slot   (h_slot),
        .head_ctrl   (h_ctrl),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // The back never pops an empty queue.
    a_no_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // The fill count follows the pushes and pops of the previous cycle.
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (q_fill == maxp_pkg::QUEUE_CNT_W'($past(q_fill) + $past(q_push)
                                              - $past(q_pop))))
        else $error("queue fill count out of step");

    // No result leaves in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// ----- verif/maxpool_2x2_stream_checker.sv -----
// ----------------------------------------------------------------------------
// maxpool_2x2_stream_checker
// Watches the sample, pooled and register channels of the 2x2 max pooling
// block and keeps its own model of the window positions and the line buffer.
// Every pooled word is compared with the oldest predicted window maximum, and
// the number of failures goes back to the testbench top.
// ----------------------------------------------------------------------------
module maxpool_2x2_stream_checker #(
    parameter int MAX_OUT_DIM = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [maxp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [maxp_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [maxp_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [maxp_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [31:0] pooled_value
    input  logic                             m_axis_tlast,
    output int                               error_count,
    output int                               waiting_results,
    output int                               pooled_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted pooled word.
    typedef struct packed {
        logic [maxp_pkg::SAMPLE_W-1:0] value;
        logic                          last;
    } pooled_word_t;

    // Model copy of the registers and the position state.
    logic [maxp_pkg::CFG_W-1:0]           chan_reg;
    logic [maxp_pkg::CFG_W-1:0]           dim_reg;
    logic [6:0]                           col_pos;
    logic [6:0]                           row_pos;
    logic [maxp_pkg::CH_W-1:0]            chan_pos;
    logic signed [maxp_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [maxp_pkg::SAMPLE_W-1:0] pair_line [MAX_OUT_DIM];
    pooled_word_t                         pooled_q [$];

    initial begin
        error_count     = 0;
        waiting_results = 0;
        pooled_seen     = 0;
    end

    // Zero counts as one, anything above the limit saturates.
    function automatic int unsigned clamp_reg(input logic [maxp_pkg::CFG_W-1:0] v,
                                              input int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Advance the model by one sample; returns 1 when a window completes.
    function automatic bit pool_sample(input logic signed [maxp_pkg::SAMPLE_W-1:0] smp,
                                       output pooled_word_t word);
        int unsigned                          span;
        int unsigned                          chans;
        int unsigned                          slot;
        bit                                   last_col;
        bit                                   last_row;
        bit                                   last_ch;
        bit                                   done;
        logic signed [maxp_pkg::SAMPLE_W-1:0] pm;
        logic signed [maxp_pkg::SAMPLE_W-1:0] upper;

        span     = 2 * clamp_reg(dim_reg, MAX_OUT_DIM);
        chans    = clamp_reg(chan_reg, maxp_pkg::MAX_CHANNELS);
        slot     = col_pos >> 1;
        last_col = (col_pos + 1 >= span);
        last_row = (row_pos + 1 >= span);
        last_ch  = (chan_pos + 1 >= chans);
        done     = 1'b0;
        word     = '0;
        if (slot >= MAX_OUT_DIM)
            slot = MAX_OUT_DIM - 1;

        if (!col_pos[0]) begin
            left_sample = smp;
        end else begin
            pm = (smp > left_sample) ? smp : left_sample;
            if (!row_pos[0]) begin
                pair_line[slot] = pm;
            end else begin
                upper      = pair_line[slot];
                word.value = (pm > upper) ? pm : upper;
                word.last  = last_col && last_row && last_ch;
                done       = 1'b1;
            end
        end

        // Raster walk: columns, then rows, then channels, wrapping at the end.
        if (!last_col) begin
            col_pos++;
        end else begin
            col_pos = '0;
            if (!last_row) begin
                row_pos++;
            end else begin
                row_pos  = '0;
                chan_pos = last_ch ? '0 : chan_pos + 1'b1;
            end
        end
        return done;
    endfunction

    // Sample everything at the rising edge; outputs are checked before the
    // new sample is predicted, since a window never leaves in its own cycle.
    always @(posedge aclk) begin : monitor
        pooled_word_t word;
        pooled_word_t want;

        if (!aresetn) begin
            chan_reg    = maxp_pkg::RESET_CHANNEL_COUNT;
            dim_reg     = maxp_pkg::RESET_OUT_DIM;
            col_pos     = '0;
            row_pos     = '0;
            chan_pos    = '0;
            left_sample = '0;
            pooled_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                pooled_seen++;
                if (pooled_q.size() == 0) begin
                    $error("pooled word with no window pending: value %0d, last %0b",
                           $signed(m_axis_tdata), m_axis_tlast);
                    error_count++;
                end else begin
                    want = pooled_q.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("pooled_value: expected %0d, actual %0d",
                               $signed(want.value), $signed(m_axis_tdata));
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("map_last: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end

            // A register write restarts the walk but keeps the line buffer.
            if (cfg_wr_en) begin
                if (cfg_index == maxp_pkg::REG_CHANNEL_COUNT)
                    chan_reg = cfg_wdata;
                else if (cfg_index == maxp_pkg::REG_OUT_DIM)
                    dim_reg = cfg_wdata;
                col_pos  = '0;
                row_pos  = '0;
                chan_pos = '0;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (pool_sample($signed(s_axis_tdata), word))
                    pooled_q.push_back(word);
            end
        end
        waiting_results = pooled_q.size();
    end

endmodule

// ----- verif/tb_maxpool_2x2_stream_top.sv -----
// ----------------------------------------------------------------------------
// tb_maxpool_2x2_stream_top
// Stimulus and verdict for the 2x2 max pooling stream block.
// A directed burst covers extreme samples, every window position of the
// maximum and the wrap after the last channel. Random segments then sweep
// register settings, extremes and out-of-range values included, under three
// idling mixes and one long output stall; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_maxpool_2x2_stream_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 8;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_WORDS  = 200;
    localparam int NUM_EXTREMES = 8;
    localparam int NUM_DIRECTED = 20;

    // Register settings at the edges of their ranges and beyond.
    localparam int EXT_CH  [NUM_EXTREMES] = '{1, 64, 0, 127, 3, 1, 2, 65};
    localparam int EXT_DIM [NUM_EXTREMES] = '{1, 1, 1, 1, 0, 64, 127, 2};

    // Five 2x2 windows over three channels of out_dim 1, then a wrap.
    localparam logic [maxp_pkg::SAMPLE_W-1:0] DIRECTED [NUM_DIRECTED] = '{
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'hFFFF_FFF9, 32'hFFFF_FFFB, 32'hFFFF_FFFD, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
        32'h0000_0005, 32'h0000_0005, 32'h1234_5678, 32'hEDCB_A987
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [maxp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [maxp_pkg::CFG_W-1:0]     cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [maxp_pkg::SAMPLE_W-1:0]  s_axis_tdata;    // [31:0] sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [maxp_pkg::SAMPLE_W-1:0]  m_axis_tdata;    // [31:0] pooled_value
    logic                           m_axis_tlast;

    int error_count;
    int waiting_results;
    int pooled_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    int samples_sent;
    int settings_used;
    int cycle_count;

    maxpool_2x2_stream_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    maxpool_2x2_stream_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .error_count     (error_count),
        .waiting_results (waiting_results),
        .pooled_seen     (pooled_seen)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $error("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, or a long hold when one is requested.
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Random words, small values that tie often, extremes and 16-bit values.
    function automatic logic [maxp_pkg::SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(3))
            0: return $urandom();
            1: begin
                v = $urandom_range(8);
                return maxp_pkg::SAMPLE_W'(v - 4);
            end
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return maxp_pkg::SAMPLE_W'($urandom_range(32'hFFFF)) - 32'h8000;
        endcase
    endfunction

    // Offer one sample word, with random gaps ahead of it, until it is taken.
    task automatic push_sample(input logic [maxp_pkg::SAMPLE_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge aclk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Drain the block: no sample offered, every window delivered, pipe empty.
    task automatic settle_block();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (waiting_results != 0)
            @(negedge aclk);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [maxp_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= maxp_pkg::CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One register setting followed by a run of samples. With no count
    // given, small maps run whole or longer, large ones a few rows.
    task automatic run_segment(input int ch, input int dim, input int count);
        int eff_ch;
        int eff_dim;
        int span;
        int map_words;
        int n;

        settle_block();
        write_reg(maxp_pkg::REG_CHANNEL_COUNT, ch);
        write_reg(maxp_pkg::REG_OUT_DIM, dim);
        settings_used++;
        eff_ch    = (ch == 0) ? 1 : (ch > maxp_pkg::MAX_CHANNELS) ? maxp_pkg::MAX_CHANNELS : ch;
        eff_dim   = (dim == 0) ? 1 : (dim > 64) ? 64 : dim;
        span      = 2 * eff_dim;
        map_words = eff_ch * span * span;
        if (count > 0)
            n = count;
        else if (map_words <= 300)
            n = map_words + $urandom_range(map_words / 2);
        else if (span >= 32)
            n = 2 * span;
        else
            n = 2 * span * $urandom_range(1, 3) + $urandom_range(3);
        repeat (n) push_sample(pick_sample());
    endtask

    // Main stimulus.
    initial begin
        int seg;
        int budget_end;
        int ch;
        int dim;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 60;
        samples_sent  = 0;
        settings_used = 0;
        seg           = 0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed windows: three channels of one output each, then a wrap.
        settle_block();
        write_reg(maxp_pkg::REG_CHANNEL_COUNT, 3);
        write_reg(maxp_pkg::REG_OUT_DIM, 1);
        settings_used++;
        for (int i = 0; i < NUM_DIRECTED; i++)
            push_sample(DIRECTED[i]);

        // Random segments under three idling mixes.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // With no idling, hold the output off long enough to fill the
            // block and stall its input while samples keep coming. The hold
            // starts only once earlier windows have drained.
            if (ph == 2) begin
                settle_block();
                hold_req = 1'b1;
                run_segment(2, 2, 120);
            end

            budget_end = samples_sent + PHASE_WORDS;
            while (samples_sent < budget_end) begin
                if (seg < NUM_EXTREMES) begin
                    ch  = EXT_CH[seg];
                    dim = EXT_DIM[seg];
                end else begin
                    ch  = ($urandom_range(9) == 0) ? $urandom_range(127)
                                                   : $urandom_range(1, 4);
                    dim = ($urandom_range(9) == 0) ? $urandom_range(8)
                                                   : $urandom_range(1, 3);
                end
                run_segment(ch, dim, 0);
                seg++;
            end
        end

        // Let the last windows come out, then stay quiet before the report.
        settle_block();
        repeat (20) @(negedge aclk);

        $display("Sent %0d sample words over %0d register settings.",
                 samples_sent, settings_used);
        $display("Checked %0d pooled words under three idling mixes and a long stall.",
                 pooled_seen);
        if (error_count == 0 && waiting_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/maxp_pkg.sv
hdl/maxp_ram.sv
hdl/maxp_queue.sv
hdl/maxp_front.sv
hdl/maxp_back.sv
hdl/maxpool_2x2_stream_top.sv
verif/maxpool_2x2_stream_checker.sv
verif/tb_maxpool_2x2_stream_top.sv
